// File: rtl/core/smra_pkg.sv
// smra_pkg: shared types and constants for the spi register access master
// no dependencies; imported by smra_front, smra_engine and spi_master_register_access

package smra_pkg;

    localparam int SMRA_QUEUE_DEPTH = 2;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_WAIT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_MASK   = 2'd2;

    localparam logic [CFG_W-1:0] HALF_PERIOD_RST = 16'd6;
    localparam logic [CFG_W-1:0] READ_WAIT_RST   = 16'd45;
    localparam logic [CFG_W-1:0] READ_MASK_RST   = 16'h8000;

    localparam logic       OP_WRITE = 1'b0;
    localparam logic       OP_READ  = 1'b1;
    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ADDR  = 3'd1,
        PH_WDATA = 3'd2,
        PH_WAIT  = 3'd3,
        PH_RDATA = 3'd4
    } t_phase;

    typedef struct packed {
        logic        cmd_valid;
        logic        opcode;
        logic [15:0] address;
        logic [15:0] burst_length;
        logic [7:0]  write_byte;
        logic        miso_level;
    } t_cmd;

    typedef struct packed {
        logic        chip_select_n;
        logic        sclk_level;
        logic        mosi_level;
        logic        byte_taken;
        logic        read_valid;
        logic [7:0]  read_data;
        logic        busy_res;
        logic        done_res;
    } t_res;

    typedef struct packed {
        logic [CFG_W-1:0] half_period_ticks;
        logic [CFG_W-1:0] read_wait_ticks;
        logic [CFG_W-1:0] read_flag_mask;
    } t_cfg;

endpackage

// File: rtl/core/smra_cmd_if.sv
// smra_cmd_if: request channel carrying one tick of pin and command inputs
// depends on nothing but the handshake convention valid/ready

interface smra_cmd_if;
    logic        valid;
    logic        ready;
    logic        cmd_valid;
    logic        opcode;
    logic [15:0] address;
    logic [15:0] burst_length;
    logic [7:0]  write_byte;
    logic        miso_level;

    modport source (
        output valid, cmd_valid, opcode, address, burst_length, write_byte, miso_level,
        input  ready
    );
    modport sink (
        input  valid, cmd_valid, opcode, address, burst_length, write_byte, miso_level,
        output ready
    );
endinterface

// File: rtl/core/smra_res_if.sv
// smra_res_if: result channel carrying pin levels and pulses of one tick
// depends on nothing but the handshake convention valid/ready

interface smra_res_if;
    logic        valid;
    logic        ready;
    logic        chip_select_n;
    logic        sclk_level;
    logic        mosi_level;
    logic        byte_taken;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        busy_res;
    logic        done_res;

    modport source (
        output valid, chip_select_n, sclk_level, mosi_level, byte_taken, read_valid,
        output read_data, busy_res, done_res,
        input  ready
    );
    modport sink (
        input  valid, chip_select_n, sclk_level, mosi_level, byte_taken, read_valid,
        input  read_data, busy_res, done_res,
        output ready
    );
    modport monitor (
        input  valid, ready, chip_select_n, sclk_level, mosi_level, byte_taken,
        input  read_valid, read_data, busy_res, done_res
    );
endinterface

// File: rtl/core/smra_front.sv
// smra_front: request intake and short queue in front of the engine
// depends on smra_pkg and smra_cmd_if

module smra_front
    import smra_pkg::*;
#(
    parameter int QUEUE_DEPTH = SMRA_QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    smra_cmd_if.sink     i_cmd,
    output logic         o_head_valid,
    output t_cmd         o_head,
    input  logic         i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_cmd             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;
    t_cmd             w_in;

    assign i_cmd.ready  = (r_count != CNT_FULL);
    assign w_push       = i_cmd.valid && i_cmd.ready;
    assign w_pop        = i_pop && (r_count != '0);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_comb begin
        w_in.cmd_valid    = i_cmd.cmd_valid;
        w_in.opcode       = i_cmd.opcode;
        w_in.address      = i_cmd.address;
        w_in.burst_length = i_cmd.burst_length;
        w_in.write_byte   = i_cmd.write_byte;
        w_in.miso_level   = i_cmd.miso_level;
    end

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (!w_push && w_pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_in;
        end
    end

endmodule

// File: rtl/core/smra_engine.sv
// smra_engine: bit timing sequencer and result register behind the queue
// depends on smra_pkg and smra_res_if

module smra_engine
    import smra_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  logic         i_head_valid,
    input  t_cmd         i_head,
    output logic         o_pop,
    smra_res_if.source   o_res
);

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bit, n_bit;
    logic [15:0] r_bytes_left, n_bytes_left;
    logic [15:0] r_tick, n_tick;
    logic [7:0]  r_shift, n_shift;
    logic [15:0] r_addr, n_addr;
    logic        r_is_read, n_is_read;
    logic        r_addr_idx, n_addr_idx;
    logic        r_sclk, n_sclk;

    logic        w_taken, w_rvalid, w_done;
    logic [7:0]  w_rdata;
    logic        w_fire;
    logic        w_half_more, w_wait_done;
    logic        w_xfer;
    t_res        w_res;
    t_res        r_res;
    logic        r_out_valid;

    assign w_fire = i_head_valid && (!r_out_valid || o_res.ready);
    assign o_pop  = w_fire;

    assign w_half_more = ({1'b0, r_tick} + 17'd1) < {1'b0, i_cfg.half_period_ticks};
    assign w_wait_done = ({1'b0, r_tick} + 17'd1) >= {1'b0, i_cfg.read_wait_ticks};

    // next state: one tick of the transfer sequencer
    always_comb begin
        n_phase      = r_phase;
        n_bit        = r_bit;
        n_bytes_left = r_bytes_left;
        n_tick       = r_tick;
        n_shift      = r_shift;
        n_addr       = r_addr;
        n_is_read    = r_is_read;
        n_addr_idx   = r_addr_idx;
        n_sclk       = r_sclk;
        w_taken      = 1'b0;
        w_rvalid     = 1'b0;
        w_done       = 1'b0;
        w_rdata      = 8'd0;
        case (r_phase)
            PH_IDLE: begin
                if (i_head.cmd_valid) begin
                    n_is_read    = i_head.opcode;
                    n_addr       = (i_head.opcode == OP_READ) ?
                                   (i_head.address | i_cfg.read_flag_mask) : i_head.address;
                    n_bytes_left = i_head.burst_length;
                    n_addr_idx   = 1'b0;
                    n_shift      = n_addr[15:8];
                    n_bit        = 3'd0;
                    n_phase      = PH_ADDR;
                    n_sclk       = 1'b1;
                    n_tick       = 16'd0;
                end
            end
            PH_WAIT: begin
                if (w_wait_done) begin
                    n_phase = PH_RDATA;
                    if (r_bytes_left == 16'd0) begin
                        n_phase = PH_IDLE;
                        n_bit   = 3'd0;
                        n_tick  = 16'd0;
                        n_sclk  = 1'b0;
                        w_done  = 1'b1;
                    end else begin
                        n_shift = 8'd0;
                        n_bit   = 3'd0;
                        n_sclk  = 1'b1;
                        n_tick  = 16'd0;
                    end
                end else begin
                    n_tick = r_tick + 16'd1;
                end
            end
            PH_ADDR, PH_WDATA, PH_RDATA: begin
                if (w_half_more) begin
                    n_tick = r_tick + 16'd1;
                end else if (r_sclk) begin
                    // sample at the end of the high half
                    if (r_phase == PH_RDATA) begin
                        n_shift = {r_shift[6:0], i_head.miso_level};
                    end
                    n_sclk = 1'b0;
                    n_tick = 16'd0;
                end else begin
                    if (r_phase != PH_RDATA) begin
                        n_shift = {r_shift[6:0], 1'b0};
                    end
                    if (r_bit != LAST_BIT) begin
                        n_bit  = r_bit + 3'd1;
                        n_sclk = 1'b1;
                        n_tick = 16'd0;
                    end else if (r_phase == PH_ADDR && !r_addr_idx) begin
                        n_addr_idx = 1'b1;
                        n_shift    = r_addr[7:0];
                        n_bit      = 3'd0;
                        n_sclk     = 1'b1;
                        n_tick     = 16'd0;
                    end else if (r_phase == PH_ADDR && r_is_read &&
                                 i_cfg.read_wait_ticks != 16'd0) begin
                        n_phase = PH_WAIT;
                        n_tick  = 16'd0;
                        n_sclk  = 1'b0;
                    end else begin
                        // next data byte, or end of burst
                        if (r_phase == PH_RDATA) begin
                            w_rvalid     = 1'b1;
                            w_rdata      = r_shift;
                            n_bytes_left = r_bytes_left - 16'd1;
                        end
                        n_phase = (r_is_read) ? PH_RDATA : PH_WDATA;
                        if (n_bytes_left == 16'd0) begin
                            n_phase = PH_IDLE;
                            n_bit   = 3'd0;
                            n_tick  = 16'd0;
                            n_sclk  = 1'b0;
                            w_done  = 1'b1;
                        end else begin
                            n_bit  = 3'd0;
                            n_sclk = 1'b1;
                            n_tick = 16'd0;
                            if (r_is_read) begin
                                n_shift = 8'd0;
                            end else begin
                                n_shift      = i_head.write_byte;
                                n_bytes_left = r_bytes_left - 16'd1;
                                w_taken      = 1'b1;
                            end
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_sclk  = 1'b0;
                n_tick  = 16'd0;
            end
        endcase
    end

    // outputs: pin levels after this tick's edge
    always_comb begin
        w_xfer              = (n_phase == PH_ADDR) || (n_phase == PH_WDATA) ||
                              (n_phase == PH_RDATA);
        w_res.chip_select_n = (n_phase == PH_IDLE);
        w_res.sclk_level    = w_xfer && n_sclk;
        w_res.mosi_level    = ((n_phase == PH_ADDR) || (n_phase == PH_WDATA)) ?
                              n_shift[7] : 1'b0;
        w_res.byte_taken    = w_taken;
        w_res.read_valid    = w_rvalid;
        w_res.read_data     = w_rdata;
        w_res.busy_res      = (n_phase != PH_IDLE);
        w_res.done_res      = w_done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_bit        <= 3'd0;
            r_bytes_left <= 16'd0;
            r_tick       <= 16'd0;
            r_shift      <= 8'd0;
            r_addr       <= 16'd0;
            r_is_read    <= 1'b0;
            r_addr_idx   <= 1'b0;
            r_sclk       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_fire) begin
                r_phase      <= n_phase;
                r_bit        <= n_bit;
                r_bytes_left <= n_bytes_left;
                r_tick       <= n_tick;
                r_shift      <= n_shift;
                r_addr       <= n_addr;
                r_is_read    <= n_is_read;
                r_addr_idx   <= n_addr_idx;
                r_sclk       <= n_sclk;
                r_out_valid  <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.chip_select_n = r_res.chip_select_n;
    assign o_res.sclk_level    = r_res.sclk_level;
    assign o_res.mosi_level    = r_res.mosi_level;
    assign o_res.byte_taken    = r_res.byte_taken;
    assign o_res.read_valid    = r_res.read_valid;
    assign o_res.read_data     = r_res.read_data;
    assign o_res.busy_res      = r_res.busy_res;
    assign o_res.done_res      = r_res.done_res;

endmodule

// File: rtl/core/spi_master_register_access.sv
// spi_master_register_access: top level, config registers, queue and engine
// depends on smra_pkg, smra_cmd_if, smra_res_if, smra_front, smra_engine
//
//   channel   dir   handshake            carries
//   i_cmd     in    valid/ready          one tick: command, write byte, miso level
//   o_res     out   valid/ready          one tick: cs_n, sclk, mosi, pulses, read byte
//   i_cfg_*   in    write enable only    half period, read wait, read flag mask
//
// one request per cycle sustained while o_res is ready; each request yields exactly one result
// a request is registered in the front queue, then in the result register
// the queue lets requests keep arriving while o_res is stalled, until its QUEUE_DEPTH entries are full
// reset (synchronous, active low) empties the queue and returns the engine to idle
// config writes land at once; change them only while the engine is idle

module spi_master_register_access
    import smra_pkg::*;
#(
    parameter int QUEUE_DEPTH = SMRA_QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    smra_cmd_if.sink             i_cmd,
    smra_res_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // configuration registers
    t_cfg r_cfg;
    logic w_head_valid;
    t_cmd w_head;
    logic w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks <= HALF_PERIOD_RST;
            r_cfg.read_wait_ticks   <= READ_WAIT_RST;
            r_cfg.read_flag_mask    <= READ_MASK_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HALF_PERIOD: r_cfg.half_period_ticks <= i_cfg_data;
                CFG_READ_WAIT:   r_cfg.read_wait_ticks   <= i_cfg_data;
                CFG_READ_MASK:   r_cfg.read_flag_mask    <= i_cfg_data;
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // front: takes requests, holds them until the engine is free
    smra_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .o_head_valid (w_head_valid),
        .o_head       (w_head),
        .i_pop        (w_pop)
    );

    // back: one tick of spi timing per popped request
    smra_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_res        (o_res)
    );

endmodule

// File: rtl/core/smra_checker.sv
// smra_checker: port-level properties of the result channel, bound to the top
// depends on the o_res ports of spi_master_register_access

module smra_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_ready,
    input  logic       i_cs_n,
    input  logic       i_sclk,
    input  logic       i_mosi,
    input  logic       i_taken,
    input  logic       i_rvalid,
    input  logic [7:0] i_rdata,
    input  logic       i_busy,
    input  logic       i_done
);

    // stalled result holds its read data, chip select and sclk
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_rdata)
            && $stable(i_cs_n) && $stable(i_sclk))
        else $error("result changed while stalled");

    a_busy_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_busy != i_cs_n)
        else $error("busy and chip select disagree");

    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_done |-> i_cs_n && !i_sclk && !i_mosi && !i_taken)
        else $error("done pulse without idle pins");

    a_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_taken |-> !i_cs_n && i_sclk && !i_rvalid)
        else $error("write byte taken outside a bit start");

    a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_rvalid |-> !i_mosi && !i_taken)
        else $error("read byte with mosi driven");

endmodule

bind spi_master_register_access smra_checker u_smra_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_res.valid),
    .i_ready  (o_res.ready),
    .i_cs_n   (o_res.chip_select_n),
    .i_sclk   (o_res.sclk_level),
    .i_mosi   (o_res.mosi_level),
    .i_taken  (o_res.byte_taken),
    .i_rvalid (o_res.read_valid),
    .i_rdata  (o_res.read_data),
    .i_busy   (o_res.busy_res),
    .i_done   (o_res.done_res)
);
